@@ hdl/uvs_pkg.sv @@
// Shared types, constants and helpers of the UV-sphere vertex generator.
// No dependencies; imported by every module of the block.
package uvs_pkg;

  localparam int P_W       = 8;
  localparam int IDX_W     = 16;
  localparam int TEX_W     = 17;
  localparam int PH_W      = 32;
  localparam int MAG_W     = 31;
  localparam int PROD_W    = 62;
  localparam int DIV_CELLS = 33;   // integer bit plus 32 fraction bits
  localparam int SIN_LAT   = 7;
  localparam int TEX_STEP  = 16;
  localparam int TH_STEP   = 31;
  localparam int PH_STEP   = 32;
  localparam int MAX_STEPS_DEF = 255;
  localparam logic [P_W-1:0] PREC_RESET = 8'd48;

  localparam logic [MAG_W-1:0] Q30_ONE = 31'd1073741824;
  localparam logic [MAG_W-1:0] SIN_C1  = 31'd1686629713;
  localparam logic [MAG_W-1:0] SIN_C3  = 31'd693598667;
  localparam logic [MAG_W-1:0] SIN_C5  = 31'd85569306;
  localparam logic [MAG_W-1:0] SIN_C7  = 31'd5026999;
  localparam logic [MAG_W-1:0] SIN_C9  = 31'd172273;
  localparam logic [15:0] Q14_MAX = 16'd16384;
  localparam logic [PH_W-1:0] QUARTER = 32'h4000_0000;

  typedef struct packed {
    logic [P_W-1:0]   r;
    logic [P_W-1:0]   s;
    logic [P_W-1:0]   p;
    logic [P_W-1:0]   rem_r;
    logic [P_W-1:0]   rem_s;
    logic [PH_W-1:0]  q_r;
    logic [PH_W-1:0]  q_s;
    logic [TEX_W-1:0] tex_u;
    logic [TEX_W-1:0] tex_v;
    logic [PH_W-1:0]  th;
    logic [PH_W-1:0]  ph;
  } div_t;

  typedef struct packed {
    logic [P_W-1:0]   r;
    logic [P_W-1:0]   s;
    logic [P_W-1:0]   p;
    logic [TEX_W-1:0] tex_u;
    logic [TEX_W-1:0] tex_v;
  } side_t;

  // one restoring division step: {quotient bit, new remainder}
  function automatic logic [P_W:0] div_step(input logic [P_W-1:0] rem,
                                            input logic [P_W-1:0] p,
                                            input logic first);
    logic [P_W:0] t;
    logic [P_W:0] d;
    t = first ? {1'b0, rem} : {rem, 1'b0};
    d = t - {1'b0, p};
    if (t >= {1'b0, p}) begin
      return {1'b1, d[P_W-1:0]};
    end
    return {1'b0, t[P_W-1:0]};
  endfunction

  // saturate a magnitude at 1.0 in Q14 and apply the sign
  function automatic logic signed [15:0] to_q14(input logic [15:0] mag,
                                                input logic neg);
    logic [15:0] m;
    m = (mag > Q14_MAX) ? Q14_MAX : mag;
    return neg ? -$signed(m) : $signed(m);
  endfunction

endpackage

@@ hdl/uvs_in_if.sv @@
// Input channel of the vertex generator: one grid point per item.
// Depends on uvs_pkg for field widths.
interface uvs_in_if;
  import uvs_pkg::*;
  logic           valid;
  logic           ready;
  logic [P_W-1:0] ring;
  logic [P_W-1:0] segment;
  modport source(output valid, ring, segment, input ready);
  modport sink(input valid, ring, segment, output ready);
endinterface

@@ hdl/uvs_out_if.sv @@
// Result channel of the vertex generator: one vertex per item.
// Depends on uvs_pkg for field widths.
interface uvs_out_if;
  import uvs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [15:0]      pos_x;
  logic signed [15:0]      pos_y;
  logic signed [15:0]      pos_z;
  logic [TEX_W-1:0]        tex_u;
  logic [TEX_W-1:0]        tex_v;
  logic [IDX_W-1:0]        idx_a;
  logic [IDX_W-1:0]        idx_b;
  logic [IDX_W-1:0]        idx_c;
  logic [IDX_W-1:0]        idx_d;
  logic [IDX_W-1:0]        idx_e;
  logic [IDX_W-1:0]        idx_f;
  logic                    quad_valid;
  modport source(output valid, pos_x, pos_y, pos_z, tex_u, tex_v, idx_a, idx_b,
                 idx_c, idx_d, idx_e, idx_f, quad_valid, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, tex_u, tex_v, idx_a, idx_b,
               idx_c, idx_d, idx_e, idx_f, quad_valid, output ready);
endinterface

@@ hdl/uvs_div_cell.sv @@
// One cell of the divider chain: one quotient bit of ring/P and segment/P.
// Depends on uvs_pkg (div_t, div_step).
module uvs_div_cell
  import uvs_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_v,
  input  div_t in_d,
  output logic out_v_r,
  output div_t out_d_r
);

  logic [P_W:0] sr;
  logic [P_W:0] ss;
  logic         rnd_r;
  logic         rnd_s;
  logic [PH_W-1:0] qr;
  logic [PH_W-1:0] qs;
  div_t         d_nxt;

  always_comb begin
    sr = div_step(in_d.rem_r, in_d.p, STEP == 0);
    ss = div_step(in_d.rem_s, in_d.p, STEP == 0);
    qr = {in_d.q_r[PH_W-2:0], sr[P_W]};
    qs = {in_d.q_s[PH_W-2:0], ss[P_W]};
    // round to nearest: up when twice the remainder reaches P
    rnd_r = {sr[P_W-1:0], 1'b0} >= {1'b0, in_d.p};
    rnd_s = {ss[P_W-1:0], 1'b0} >= {1'b0, in_d.p};
    d_nxt = in_d;
    d_nxt.rem_r = sr[P_W-1:0];
    d_nxt.rem_s = ss[P_W-1:0];
    d_nxt.q_r = qr;
    d_nxt.q_s = qs;
    if (STEP == TEX_STEP) begin
      d_nxt.tex_u = qs[TEX_W-1:0] + TEX_W'(rnd_s);
      d_nxt.tex_v = qr[TEX_W-1:0] + TEX_W'(rnd_r);
    end
    if (STEP == TH_STEP) begin
      d_nxt.th = qr + PH_W'(rnd_r);
    end
    if (STEP == PH_STEP) begin
      d_nxt.ph = qs + PH_W'(rnd_s);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d_r <= d_nxt;
    end
  end

endmodule

@@ hdl/uvs_sin_unit.sv @@
// Pipelined sine of a 32-bit phase: quadrant fold and odd polynomial in Q30.
// Depends on uvs_pkg for coefficients and widths.
module uvs_sin_unit
  import uvs_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [PH_W-1:0]  phase,
  output logic [MAG_W-1:0] mag_r,
  output logic             neg_r
);

  logic [MAG_W-1:0] f_r   [SIN_LAT-1];
  logic [MAG_W-1:0] f2_r  [SIN_LAT-3];
  logic [MAG_W-1:0] acc_r [1:SIN_LAT-3];
  logic             n_r   [SIN_LAT-1];
  logic [MAG_W-1:0] f0;
  logic [PROD_W-1:0] p_sq;
  logic [PROD_W-1:0] p_c9;
  logic [PROD_W-1:0] p_a3;
  logic [PROD_W-1:0] p_a4;
  logic [PROD_W-1:0] p_a5;
  logic [PROD_W-1:0] p_out;

  always_comb begin
    f0 = {1'b0, phase[29:0]};
    if (phase[30]) begin
      f0 = Q30_ONE - {1'b0, phase[29:0]};
    end
    p_sq  = f_r[0] * f_r[0];
    p_c9  = f2_r[0] * SIN_C9;
    p_a3  = f2_r[1] * acc_r[1];
    p_a4  = f2_r[2] * acc_r[2];
    p_a5  = f2_r[3] * acc_r[3];
    p_out = f_r[5] * acc_r[4];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_r[0] <= f0;
      n_r[0] <= phase[31];
      for (int i = 1; i < SIN_LAT - 1; i++) begin
        f_r[i] <= f_r[i-1];
        n_r[i] <= n_r[i-1];
      end
      f2_r[0] <= p_sq[60:30];
      for (int i = 1; i < SIN_LAT - 3; i++) begin
        f2_r[i] <= f2_r[i-1];
      end
      acc_r[1] <= SIN_C7 - p_c9[60:30];
      acc_r[2] <= SIN_C5 - p_a3[60:30];
      acc_r[3] <= SIN_C3 - p_a4[60:30];
      acc_r[4] <= SIN_C1 - p_a5[60:30];
      mag_r <= p_out[60:30];
      neg_r <= n_r[SIN_LAT-2];
    end
  end

endmodule

@@ hdl/uv_sphere_vertex_generator.sv @@
// UV-sphere vertex generator: divider cell chain, four sine units, output stage.
// Takes one item per cycle unless stalled; each item passes, in order, the
// 33-cell divider chain, four sine pipelines, product stage and output register.
// The pipeline stalls only while a result waits and the last stage is full.
// Synchronous active-low reset clears all valid bits and sets precision to 48.
// Depends on uvs_pkg, uvs_in_if, uvs_out_if, uvs_div_cell, uvs_sin_unit.
module uv_sphere_vertex_generator
  import uvs_pkg::*;
#(
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  uvs_in_if.sink         in_ch,
  uvs_out_if.source      out_ch,
  input  logic           cfg_we,
  input  logic [P_W-1:0] cfg_wdata
);

  logic [P_W-1:0] prec_r;
  logic           en;
  logic [P_W-1:0] p_eff;
  logic [P_W-1:0] r_c;
  logic [P_W-1:0] s_c;
  div_t           d0;
  div_t           chain_d [DIV_CELLS+1];
  logic           chain_v [DIV_CELLS+1];
  side_t          side_r  [SIN_LAT];
  logic           sv_r    [SIN_LAT];
  logic [MAG_W-1:0] st;
  logic [MAG_W-1:0] ct;
  logic [MAG_W-1:0] sp;
  logic [MAG_W-1:0] cp;
  logic           st_n, ct_n, sp_n, cp_n;
  logic [PROD_W-1:0] px_r, pz_r;
  logic [MAG_W-1:0]  cty_r;
  logic           xn_r, yn_r, zn_r;
  side_t          ps_r;
  logic           prod_v_r;
  logic [IDX_W-1:0] a_r, c_r;
  logic           qv_r;
  logic [IDX_W:0]   a_full;
  logic [P_W:0]     w;
  logic [PROD_W-1:0] xr, zr;
  logic [MAG_W-1:0]  yr;
  logic           out_v_r;
  logic           load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prec_r <= PREC_RESET;
    end else if (cfg_we) begin
      prec_r <= cfg_wdata;
    end
  end

  // stall only when a result waits and the last stage holds an item
  assign en = !prod_v_r || !out_v_r || out_ch.ready;
  assign in_ch.ready = en;

  always_comb begin
    p_eff = prec_r;
    if (prec_r == '0) begin
      p_eff = P_W'(1);
    end
    if (int'(prec_r) > MAX_STEPS) begin
      p_eff = P_W'(MAX_STEPS);
    end
    r_c = (in_ch.ring > p_eff) ? p_eff : in_ch.ring;
    s_c = (in_ch.segment > p_eff) ? p_eff : in_ch.segment;
    d0 = '0;
    d0.r = r_c;
    d0.s = s_c;
    d0.p = p_eff;
    d0.rem_r = r_c;
    d0.rem_s = s_c;
  end

  assign chain_d[0] = d0;
  assign chain_v[0] = in_ch.valid && en;

  for (genvar k = 0; k < DIV_CELLS; k++) begin : g_cell
    uvs_div_cell #(.STEP(k)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_v    (chain_v[k]),
      .in_d    (chain_d[k]),
      .out_v_r (chain_v[k+1]),
      .out_d_r (chain_d[k+1])
    );
  end

  uvs_sin_unit u_sin_th (.clk(clk), .en(en), .phase(chain_d[DIV_CELLS].th),
                         .mag_r(st), .neg_r(st_n));
  uvs_sin_unit u_cos_th (.clk(clk), .en(en), .phase(chain_d[DIV_CELLS].th + QUARTER),
                         .mag_r(ct), .neg_r(ct_n));
  uvs_sin_unit u_sin_ph (.clk(clk), .en(en), .phase(chain_d[DIV_CELLS].ph),
                         .mag_r(sp), .neg_r(sp_n));
  uvs_sin_unit u_cos_ph (.clk(clk), .en(en), .phase(chain_d[DIV_CELLS].ph + QUARTER),
                         .mag_r(cp), .neg_r(cp_n));

  // side data delayed to line up with the sine results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SIN_LAT; i++) begin
        sv_r[i] <= 1'b0;
      end
    end else if (en) begin
      sv_r[0] <= chain_v[DIV_CELLS];
      for (int i = 1; i < SIN_LAT; i++) begin
        sv_r[i] <= sv_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0].r     <= chain_d[DIV_CELLS].r;
      side_r[0].s     <= chain_d[DIV_CELLS].s;
      side_r[0].p     <= chain_d[DIV_CELLS].p;
      side_r[0].tex_u <= chain_d[DIV_CELLS].tex_u;
      side_r[0].tex_v <= chain_d[DIV_CELLS].tex_v;
      for (int i = 1; i < SIN_LAT; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // product stage: x and z magnitudes, grid indices
  always_comb begin
    w = {1'b0, side_r[SIN_LAT-1].p} + (P_W+1)'(1);
    a_full = (IDX_W+1)'(side_r[SIN_LAT-1].r) * (IDX_W+1)'(w) +
             (IDX_W+1)'(side_r[SIN_LAT-1].s);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else if (en) begin
      prod_v_r <= sv_r[SIN_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r  <= cp * st;
      pz_r  <= sp * st;
      cty_r <= ct;
      xn_r  <= !cp_n;
      yn_r  <= !ct_n;
      zn_r  <= sp_n;
      ps_r  <= side_r[SIN_LAT-1];
      a_r   <= a_full[IDX_W-1:0];
      c_r   <= a_full[IDX_W-1:0] + IDX_W'(w);
      qv_r  <= (side_r[SIN_LAT-1].r < side_r[SIN_LAT-1].p) &&
               (side_r[SIN_LAT-1].s < side_r[SIN_LAT-1].p);
    end
  end

  // output register
  assign load = prod_v_r && en;
  assign xr = px_r + (PROD_W'(1) << 45);
  assign zr = pz_r + (PROD_W'(1) << 45);
  assign yr = cty_r + (MAG_W'(1) << 15);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (load) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ch.pos_x      <= to_q14(xr[61:46], xn_r);
      out_ch.pos_y      <= to_q14({1'b0, yr[30:16]}, yn_r);
      out_ch.pos_z      <= to_q14(zr[61:46], zn_r);
      out_ch.tex_u      <= ps_r.tex_u;
      out_ch.tex_v      <= ps_r.tex_v;
      out_ch.idx_a      <= qv_r ? a_r : '0;
      out_ch.idx_b      <= qv_r ? a_r + IDX_W'(1) : '0;
      out_ch.idx_c      <= qv_r ? c_r : '0;
      out_ch.idx_d      <= qv_r ? a_r + IDX_W'(1) : '0;
      out_ch.idx_e      <= qv_r ? c_r + IDX_W'(1) : '0;
      out_ch.idx_f      <= qv_r ? c_r : '0;
      out_ch.quad_valid <= qv_r;
    end
  end

  assign out_ch.valid = out_v_r;

`ifndef NO_ASSERTIONS
  a_quad_b: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.quad_valid |->
      out_ch.idx_e == out_ch.idx_c + 16'd1 && out_ch.idx_b == out_ch.idx_a + 16'd1)
    else $error("quad indices inconsistent");
  a_no_quad: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.quad_valid |-> out_ch.idx_a == 16'd0 && out_ch.idx_f == 16'd0)
    else $error("indices not cleared for edge point");
  a_y_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.pos_y >= -16'sd16384 && out_ch.pos_y <= 16'sd16384)
    else $error("pos_y out of range");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    prod_v_r && out_v_r && !out_ch.ready |=> prod_v_r && out_v_r)
    else $error("item dropped during stall");
`endif

endmodule

@@ sim/uvs_tb_chk.sv @@
// Vertex checker: watches both channels, predicts each vertex and compares.
// Depends on uvs_pkg, uvs_in_if, uvs_out_if.
`timescale 1ns / 100ps
module uvs_tb_chk
  import uvs_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  uvs_in_if              in_ch,
  uvs_out_if             out_ch,
  input  logic           cfg_we,
  input  logic [P_W-1:0] cfg_wdata,
  output int             fail_count,
  output int             pending
);

  typedef struct {
    logic [15:0]      x, y, z;
    logic [TEX_W-1:0] u, v;
    logic [IDX_W-1:0] ia, ib, ic, id, ie, ixf;
    logic             quad;
  } vertex_t;

  vertex_t         vertex_q[$];
  logic [P_W-1:0]  steps;

  function automatic logic [63:0] qsin(input logic [63:0] f);
    logic [63:0] f2, acc;
    f2 = (f * f) >> 30;
    acc = 64'(SIN_C7) - ((f2 * 64'(SIN_C9)) >> 30);
    acc = 64'(SIN_C5) - ((f2 * acc) >> 30);
    acc = 64'(SIN_C3) - ((f2 * acc) >> 30);
    acc = 64'(SIN_C1) - ((f2 * acc) >> 30);
    return (f * acc) >> 30;
  endfunction

  // magnitude in Q30, sign in neg
  function automatic logic [63:0] psin(input logic [31:0] ph, output logic neg);
    logic [63:0] f;
    f = {34'd0, ph[29:0]};
    if (ph[30]) f = 64'(Q30_ONE) - f;
    neg = ph[31];
    return qsin(f);
  endfunction

  function automatic logic [15:0] sgn16(input logic [63:0] m, input logic neg);
    logic [15:0] v;
    v = (m > 64'd16384) ? 16'd16384 : m[15:0];
    return neg ? 16'(-v) : v;
  endfunction

  function automatic vertex_t predict_vertex(input logic [7:0] ring_i,
                                             input logic [7:0] seg_i);
    vertex_t e;
    logic [63:0] p, r, s, st, ct, sp, cp, w, a, c;
    logic [31:0] th, ph;
    logic n0, n1, n2, n3;
    p = steps;
    if (p == 0) p = 1;
    if (p > 255) p = 255;
    r = (ring_i > p) ? p : ring_i;
    s = (seg_i > p) ? p : seg_i;
    th = 32'(((r << 32) + p) / (2 * p));
    ph = 32'(((s << 32) + (p >> 1)) / p);
    st = psin(th, n0);
    ct = psin(th + QUARTER, n1);
    sp = psin(ph, n2);
    cp = psin(ph + QUARTER, n3);
    e.x = sgn16((cp * st + (64'd1 << 45)) >> 46, !n3);
    e.y = sgn16((ct + (64'd1 << 15)) >> 16, !n1);
    e.z = sgn16((sp * st + (64'd1 << 45)) >> 46, n2);
    e.u = 17'(((s << 16) + (p >> 1)) / p);
    e.v = 17'(((r << 16) + (p >> 1)) / p);
    e.quad = (r < p) && (s < p);
    w = p + 1;
    a = r * w + s;
    c = (r + 1) * w + s;
    if (e.quad) begin
      e.ia = a[15:0]; e.ib = 16'(a + 1); e.ic = c[15:0];
      e.id = 16'(a + 1); e.ie = 16'(c + 1); e.ixf = c[15:0];
    end else begin
      {e.ia, e.ib, e.ic, e.id, e.ie, e.ixf} = '0;
    end
    return e;
  endfunction

  task automatic cmp(input string name, input logic [16:0] exp_v,
                     input logic [16:0] act);
    if (exp_v !== act) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act);
      fail_count++;
    end
  endtask

  assign pending = vertex_q.size();

  always @(posedge clk) begin
    vertex_t e;
    if (!rst_n) begin
      steps <= PREC_RESET;
      fail_count <= 0;
    end else begin
      if (cfg_we) steps <= cfg_wdata;
      if (in_ch.valid && in_ch.ready)
        vertex_q.push_back(predict_vertex(in_ch.ring, in_ch.segment));
      if (out_ch.valid && out_ch.ready) begin
        if (vertex_q.size() == 0) begin
          $error("vertex with no expectation waiting");
          fail_count++;
        end else begin
          e = vertex_q.pop_front();
          cmp("pos_x", 17'(e.x), 17'(out_ch.pos_x[15:0]));
          cmp("pos_y", 17'(e.y), 17'(out_ch.pos_y[15:0]));
          cmp("pos_z", 17'(e.z), 17'(out_ch.pos_z[15:0]));
          cmp("tex_u", e.u, out_ch.tex_u);
          cmp("tex_v", e.v, out_ch.tex_v);
          cmp("idx_a", 17'(e.ia), 17'(out_ch.idx_a));
          cmp("idx_b", 17'(e.ib), 17'(out_ch.idx_b));
          cmp("idx_c", 17'(e.ic), 17'(out_ch.idx_c));
          cmp("idx_d", 17'(e.id), 17'(out_ch.idx_d));
          cmp("idx_e", 17'(e.ie), 17'(out_ch.idx_e));
          cmp("idx_f", 17'(e.ixf), 17'(out_ch.idx_f));
          cmp("quad_valid", 17'(e.quad), 17'(out_ch.quad_valid));
        end
      end
    end
  end

endmodule

@@ sim/testbench.sv @@
// Top of the vertex generator testbench: clock, reset, stimulus and verdict.
// Depends on uvs_pkg, the channel interfaces, the block and uvs_tb_chk.
`timescale 1ns / 100ps
module testbench;
  import uvs_pkg::*;

  localparam int LATENCY = 42;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           cfg_we = 1'b0;
  logic [P_W-1:0] cfg_wdata = '0;
  int             fail_count, pending;
  int             send_idle = 0, recv_idle = 0;
  bit             hold_off = 1'b0;
  logic [P_W-1:0] cur_steps = PREC_RESET;
  logic [7:0]     steps_set [6] = '{8'd48, 8'd0, 8'd1, 8'd255, 8'd7, 8'd100};

  uvs_in_if  in_ch();
  uvs_out_if out_ch();

  uv_sphere_vertex_generator dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  uvs_tb_chk chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  always #6 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.ring = '0;
    in_ch.segment = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic send_point(input logic [7:0] ring_i, input logic [7:0] seg_i);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.ring <= ring_i;
    in_ch.segment <= seg_i;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic set_steps(input logic [7:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    cur_steps <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // mostly in-range grid points, some at or past P and some fully random
  task automatic random_points(input int n);
    int pe;
    logic [7:0] r, s;
    for (int i = 0; i < n; i++) begin
      pe = (cur_steps == 0) ? 1 : int'(cur_steps);
      case ($urandom_range(9))
        0: begin r = 8'($urandom); s = 8'($urandom); end
        1: begin r = 8'(pe + $urandom_range(3)); s = 8'($urandom_range(pe)); end
        default: begin r = 8'($urandom_range(pe)); s = 8'($urandom_range(pe)); end
      endcase
      send_point(r, s);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: corners, poles, clamped steps, non-quad points
    send_point(8'd0, 8'd0);
    send_point(8'd48, 8'd48);
    send_point(8'd24, 8'd12);
    send_point(8'd47, 8'd47);
    send_point(8'd255, 8'd255);
    send_point(8'd0, 8'd255);
    send_point(8'd170, 8'd85);
    send_point(8'd12, 8'd36);
    set_steps(8'd0);
    send_point(8'd0, 8'd0);
    send_point(8'd1, 8'd1);
    send_point(8'd2, 8'd0);
    set_steps(8'd255);
    send_point(8'd254, 8'd254);
    send_point(8'd255, 8'd0);
    send_point(8'd128, 8'd191);
    send_point(8'd85, 8'd170);
    set_steps(8'd48);

    // long receiver hold-off so the pipeline backs up into the input
    hold_off = 1'b1;
    fork
      begin
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      random_points(120);
    join

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 6 : (ph == 1) ? 47 : 0;
      recv_idle = (ph == 0) ? 47 : (ph == 1) ? 6 : 0;
      for (int k = 0; k < 6; k++) begin
        set_steps(k == 0 ? 8'($urandom) : steps_set[k]);
        random_points(80);
      end
    end
    drain();
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ files.f @@
hdl/uvs_pkg.sv
hdl/uvs_in_if.sv
hdl/uvs_out_if.sv
hdl/uvs_div_cell.sv
hdl/uvs_sin_unit.sv
hdl/uv_sphere_vertex_generator.sv
sim/uvs_tb_chk.sv
sim/testbench.sv
